// File: hdl/cts_pkg.sv
// Shared constants, codes and transaction types of the cooperative task scheduler.
`default_nettype none

package cts_pkg;

  // Table size, tick length and dispatch result limit
  localparam int unsigned MaxTasks    = 16;
  localparam int unsigned TickMs      = 10;
  localparam int unsigned ResultLimit = 16;

  // Derived widths
  localparam int unsigned IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW = $clog2(MaxTasks + 1);
  localparam int unsigned ResW = $clog2(ResultLimit + 1);

  // Divide by the tick length as a multiply by the rounded-up reciprocal and a shift,
  // exact for every 32-bit dividend
  localparam int unsigned DivShift = $clog2(TickMs);
  localparam logic [32:0] DivRecip =
    33'(((64'd1 << (32 + DivShift)) + 64'(TickMs) - 64'd1) / 64'(TickMs));

  // Operation codes
  localparam logic [2:0] FuncClear    = 3'd0;
  localparam logic [2:0] FuncAdd      = 3'd1;
  localparam logic [2:0] FuncTick     = 3'd2;
  localparam logic [2:0] FuncDispatch = 3'd3;
  localparam logic [2:0] FuncDelete   = 3'd4;

  // Status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusBadIndex = 2'd2;
  localparam logic [1:0] StatusNone     = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  task_id;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
    logic [3:0]  row_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] run_id;
    logic [3:0] row;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  pending;
  } row_t;

endpackage

`default_nettype wire

// File: hdl/cooperative_task_scheduler.sv
// Top level of the cooperative task scheduler: row table, sequencer and divider.
//
// Usage: one input channel (in_valid_i / in_stall_o, in_item_i) carries an operation,
// one output channel (out_valid_o / out_stall_i, out_item_o) carries its results.
// A transaction moves at a clock edge with valid high and stall low. in_stall_o is
// high while an operation is in progress; the block works on one operation at a time.
// Every operation but an unused code gives one result, dispatch one per ready row (at
// most ResultLimit) or a single StatusNone result if no row is ready, and the final
// result of an operation has last set. An unused code is taken and dropped.
// Clear, delete and a failed add go straight to the result. An add divides the delay,
// then the period, by the tick length with one shared multiply by its reciprocal.
// In a tick the sequencer updates one row per cycle. A dispatch examines one row per
// cycle, but holds while the output register is stalled and a staged ready row waits.
// The next operation is taken in the cycle after the final result is loaded.
// A stalled receiver holds the output register; dispatch waits on it before it
// stages the next ready row. Reset empties the table and drops any held result;
// the table storage itself is not cleared.
`default_nettype none

module cooperative_task_scheduler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cts_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cts_pkg::out_item_t  out_item_o
);
  import cts_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StDivDly,
    StDivPer,
    StTick,
    StDisp,
    StResp
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [ResW-1:0]  n_q, n_d;
  logic             stg_v_q, stg_v_d;
  logic [7:0]       stg_id_q, stg_id_d;
  logic [3:0]       stg_row_q, stg_row_d;
  out_item_t        res_q, res_d;
  logic [7:0]       id_q, id_d;
  logic [31:0]      per_q, per_d;
  logic [31:0]      dly_q, dly_d;
  logic             out_valid_q;
  out_item_t        out_q;

  row_t             tbl_q [MaxTasks];

  logic             push_en;
  out_item_t        push_item;
  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  row_t             wr_row;
  logic             rm_en;
  logic [IdxW-1:0]  rm_idx;

  logic             slot_free;
  row_t             cur;
  logic             rows_done;
  logic [7:0]       i_ext;
  logic [7:0]       idx_ext;
  logic [7:0]       cnt_ext;
  logic [31:0]      mul_a;
  logic [64:0]      mul_p;
  logic [31:0]      div_quo;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign cur       = tbl_q[i_q[IdxW-1:0]];
  assign rows_done = (i_q >= count_q);
  assign i_ext     = 8'(i_q);
  assign idx_ext   = 8'(in_item_i.row_index);
  assign cnt_ext   = 8'(count_q);

  // Shared divide by the tick length: delay first, then period
  assign mul_a   = (state_q == StDivPer) ? per_q : dly_q;
  assign mul_p   = {33'd0, mul_a} * {32'd0, DivRecip};
  assign div_quo = 32'(mul_p >> (32 + DivShift));

  // Sequence the operation
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    i_d       = i_q;
    n_d       = n_q;
    stg_v_d   = stg_v_q;
    stg_id_d  = stg_id_q;
    stg_row_d = stg_row_q;
    res_d     = res_q;
    id_d      = id_q;
    per_d     = per_q;
    dly_d     = dly_q;
    push_en   = 1'b0;
    push_item = res_q;
    wr_en     = 1'b0;
    wr_idx    = i_q[IdxW-1:0];
    wr_row    = cur;
    rm_en     = 1'b0;
    rm_idx    = i_q[IdxW-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          res_d = '{run_id: 8'd0, row: 4'd0, status: StatusOk, last: 1'b1};
          unique case (in_item_i.func)
            FuncClear: begin
              count_d = '0;
              state_d = StResp;
            end
            FuncAdd: begin
              if (count_q >= CntW'(MaxTasks)) begin
                res_d.status = StatusFull;
                state_d      = StResp;
              end else begin
                id_d    = in_item_i.task_id;
                per_d   = in_item_i.period_ms;
                dly_d   = in_item_i.delay_ms;
                state_d = StDivDly;
              end
            end
            FuncTick: begin
              i_d     = '0;
              state_d = StTick;
            end
            FuncDispatch: begin
              i_d     = '0;
              n_d     = '0;
              stg_v_d = 1'b0;
              state_d = StDisp;
            end
            FuncDelete: begin
              res_d.row = in_item_i.row_index;
              if (idx_ext >= cnt_ext) begin
                res_d.status = StatusBadIndex;
              end else begin
                rm_en   = 1'b1;
                rm_idx  = idx_ext[IdxW-1:0];
                count_d = count_q - 1'b1;
              end
              state_d = StResp;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end

      StDivDly: begin
        dly_d   = div_quo;
        state_d = StDivPer;
      end

      StDivPer: begin
        // Append the new row
        wr_en   = 1'b1;
        wr_idx  = count_q[IdxW-1:0];
        wr_row  = '{id: id_q, delay: dly_q, period: div_quo, pending: 8'd0};
        count_d = count_q + 1'b1;
        i_d     = count_q;
        res_d   = '{run_id: 8'd0, row: cnt_ext[3:0], status: StatusOk, last: 1'b1};
        state_d = StResp;
      end

      StTick: begin
        if (rows_done) begin
          res_d   = '{run_id: 8'd0, row: 4'd0, status: StatusOk, last: 1'b1};
          state_d = StResp;
        end else begin
          // Count down, or reload and raise the pending count
          wr_en = 1'b1;
          if (cur.delay != 32'd0) begin
            wr_row.delay = cur.delay - 32'd1;
          end else begin
            wr_row.delay = cur.period - 32'd1;
            if (cur.pending != 8'hFF) begin
              wr_row.pending = cur.pending + 8'd1;
            end
          end
          i_d = i_q + 1'b1;
        end
      end

      StDisp: begin
        if (rows_done || (n_q == ResW'(ResultLimit))) begin
          if (stg_v_q) begin
            res_d = '{run_id: stg_id_q, row: stg_row_q, status: StatusOk, last: 1'b1};
          end else begin
            res_d = '{run_id: 8'd0, row: 4'd0, status: StatusNone, last: 1'b1};
          end
          state_d = StResp;
        end else if (cur.pending != 8'd0) begin
          // Hold until the previous ready row has left
          if (!stg_v_q || slot_free) begin
            if (stg_v_q) begin
              push_en   = 1'b1;
              push_item = '{run_id: stg_id_q, row: stg_row_q, status: StatusOk, last: 1'b0};
            end
            stg_v_d   = 1'b1;
            stg_id_d  = cur.id;
            stg_row_d = i_ext[3:0];
            n_d       = n_q + 1'b1;
            if (cur.period == 32'd0) begin
              // Drop a one-shot row and examine the row that moves in
              rm_en   = 1'b1;
              count_d = count_q - 1'b1;
            end else begin
              wr_en          = 1'b1;
              wr_row.pending = cur.pending - 8'd1;
              i_d            = i_q + 1'b1;
            end
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      StResp: begin
        if (slot_free) begin
          push_en   = 1'b1;
          push_item = res_q;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      i_q         <= '0;
      n_q         <= '0;
      stg_v_q     <= 1'b0;
      stg_id_q    <= '0;
      stg_row_q   <= '0;
      res_q       <= '0;
      id_q        <= '0;
      per_q       <= '0;
      dly_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      i_q       <= i_d;
      n_q       <= n_d;
      stg_v_q   <= stg_v_d;
      stg_id_q  <= stg_id_d;
      stg_row_q <= stg_row_d;
      res_q     <= res_d;
      id_q      <= id_d;
      per_q     <= per_d;
      dly_q     <= dly_d;
      if (push_en) begin
        out_valid_q <= 1'b1;
        out_q       <= push_item;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Shift rows down over a removed row, then write one row
  always_ff @(posedge clk_i) begin
    if (rm_en) begin
      for (int j = 0; j < int'(MaxTasks) - 1; j++) begin
        if (IdxW'(j) >= rm_idx) begin
          tbl_q[j] <= tbl_q[j+1];
        end
      end
    end
    if (wr_en) begin
      tbl_q[wr_idx] <= wr_row;
    end
  end

endmodule

`default_nettype wire
